>>> design/skpl_pkg.sv
// Shared types and constants for the sorted key priority list.
package skpl_pkg;

    localparam int KEY_W  = 32;
    localparam int PAY_W  = 32;
    localparam int KIND_W = 3;

    localparam logic [KIND_W-1:0] KIND_PREPEND    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE_HD  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE_KEY = 3'd4;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PREPEND,
        OP_APPEND,
        OP_REMOVE_HD,
        OP_INSERT,
        OP_REMOVE_KEY
    } op_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } in_item_t;

    typedef struct packed {
        status_t                 status;
        logic [PAY_W-1:0]        payload_out;
        logic signed [KEY_W-1:0] key_out;
    } out_item_t;

    // Contents of one cell, as seen by its neighbours.
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } entry_t;

    // Operation broadcast to every cell of the row.
    typedef struct packed {
        logic                    en;
        op_t                     op;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } cmd_t;

    // What a cell reports when it is the one that the operation lands on.
    typedef struct packed {
        logic                    hit;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } report_t;

endpackage

>>> design/skpl_cell.sv
// One slot of the list: holds an entry and shifts towards either neighbour.
module skpl_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  skpl_pkg::cmd_t   cmd,
    input  skpl_pkg::entry_t left_entry,
    input  skpl_pkg::entry_t right_entry,
    input  logic             hit_in,
    output skpl_pkg::entry_t self_entry,
    output logic             hit_out,
    output skpl_pkg::report_t report
);
    import skpl_pkg::*;

    logic                    valid_reg, valid_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0]        payload_reg, payload_next;
    logic                    match;
    logic                    is_insert;
    logic signed [KEY_W-1:0] new_key;

    always_comb begin
        match     = 1'b0;
        is_insert = 1'b0;
        new_key   = cmd.key;
        case (cmd.op)
            OP_PREPEND: begin
                match     = 1'b1;
                is_insert = 1'b1;
                new_key   = valid_reg ? key_reg - KEY_W'(1) : '0;
            end
            OP_APPEND: begin
                match     = !valid_reg;
                is_insert = 1'b1;
                new_key   = left_entry.valid ? left_entry.key + KEY_W'(1) : '0;
            end
            OP_INSERT: begin
                match     = !valid_reg || (cmd.key < key_reg);
                is_insert = 1'b1;
            end
            OP_REMOVE_HD:  match = valid_reg;
            OP_REMOVE_KEY: match = valid_reg && (key_reg == cmd.key);
            default: begin
                match = 1'b0;
            end
        endcase
    end

    always_comb begin
        valid_next   = valid_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        if (cmd.en) begin
            if (is_insert) begin
                if (hit_in) begin
                    valid_next   = left_entry.valid;
                    key_next     = left_entry.key;
                    payload_next = left_entry.payload;
                end else if (match) begin
                    valid_next   = 1'b1;
                    key_next     = new_key;
                    payload_next = cmd.payload;
                end
            end else if (hit_in || match) begin
                valid_next   = right_entry.valid;
                key_next     = right_entry.key;
                payload_next = right_entry.payload;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign hit_out            = hit_in || match;
    assign self_entry.valid   = valid_reg;
    assign self_entry.key     = key_reg;
    assign self_entry.payload = payload_reg;
    assign report.hit         = match && !hit_in;
    assign report.key         = is_insert ? new_key : key_reg;
    assign report.payload     = is_insert ? '0 : payload_reg;

endmodule

>>> design/sorted_key_priority_list_top.sv
// Top level of the sorted key priority list: a row of cells and a result register.
// Every operation completes in the cycle its request is accepted; the result appears
// in the next cycle and one request is taken per cycle while results are drained.
// The per-cycle work is one broadcast compare in every cell and a first-hit chain
// along the row of cells, which sets the clock period.
// Synchronous active-low reset empties the list and the result register at once.
module sorted_key_priority_list_top #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  skpl_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output skpl_pkg::out_item_t m_data
);
    import skpl_pkg::*;

    entry_t    cells [LIST_DEPTH];
    report_t   reports [LIST_DEPTH];
    logic      hit_chain [LIST_DEPTH+1];
    logic [LIST_DEPTH-1:0] cell_valid;
    cmd_t      cmd;
    report_t   found;
    op_t       op_decoded;
    logic      accept;
    logic      list_full;
    logic      list_empty;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;
    status_t   status_dec;
    status_t   status;

    assign accept     = s_valid && s_ready;
    assign list_full  = cells[LIST_DEPTH-1].valid;
    assign list_empty = !cells[0].valid;

    always_comb begin
        op_decoded = OP_NONE;
        status_dec = STATUS_OK;
        unique case (s_data.kind) inside
            KIND_PREPEND, KIND_APPEND, KIND_INSERT: begin
                if (list_full) begin
                    status_dec = STATUS_FULL;
                end else if (s_data.kind == KIND_PREPEND) begin
                    op_decoded = OP_PREPEND;
                end else if (s_data.kind == KIND_APPEND) begin
                    op_decoded = OP_APPEND;
                end else begin
                    op_decoded = OP_INSERT;
                end
            end
            KIND_REMOVE_HD: begin
                if (list_empty) begin
                    status_dec = STATUS_EMPTY;
                end else begin
                    op_decoded = OP_REMOVE_HD;
                end
            end
            KIND_REMOVE_KEY: begin
                if (list_empty) begin
                    status_dec = STATUS_EMPTY;
                end else begin
                    op_decoded = OP_REMOVE_KEY;
                end
            end
            default: begin
                op_decoded = OP_NONE;
            end
        endcase
    end

    always_comb begin
        status = status_dec;
        if (op_decoded == OP_REMOVE_KEY && !hit_chain[LIST_DEPTH]) begin
            status = STATUS_NOT_FOUND;
        end
    end

    assign cmd.en      = accept;
    assign cmd.op      = op_decoded;
    assign cmd.key     = s_data.key;
    assign cmd.payload = s_data.payload;

    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        entry_t left_entry;
        entry_t right_entry;
        if (i == 0) begin : g_head
            assign left_entry = '0;
        end else begin : g_body
            assign left_entry = cells[i-1];
        end
        if (i == LIST_DEPTH - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = cells[i+1];
        end
        skpl_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .hit_in      (hit_chain[i]),
            .self_entry  (cells[i]),
            .hit_out     (hit_chain[i+1]),
            .report      (reports[i])
        );
        assign cell_valid[i] = cells[i].valid;
    end

    always_comb begin
        found = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (reports[i].hit) begin
                found = found | reports[i];
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        if (accept) begin
            out_valid_next            = 1'b1;
            out_data_next.status      = status;
            out_data_next.payload_out = '0;
            out_data_next.key_out     = '0;
            if (status == STATUS_OK && op_decoded != OP_NONE) begin
                out_data_next.payload_out = found.payload;
                out_data_next.key_out     = found.key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign s_ready = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    // Occupied cells always form an unbroken run from the head.
    a_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        &(~cell_valid[LIST_DEPTH-1:1] | cell_valid[LIST_DEPTH-2:0]))
        else $error("list entries are not packed towards the head");

    // A head removal from a non-empty list drops exactly one entry.
    a_remove_hd: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.kind == KIND_REMOVE_HD && cell_valid[0] |=>
        $countones(cell_valid) == $past($countones(cell_valid)) - 1)
        else $error("head removal did not drop one entry");

    // An insert request into a full list leaves the occupied cells unchanged.
    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && list_full && (s_data.kind == KIND_PREPEND ||
        s_data.kind == KIND_APPEND || s_data.kind == KIND_INSERT) |=>
        $stable(cell_valid))
        else $error("full list changed on a rejected insert");

    // A successful insert adds exactly one entry.
    a_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !list_full && (s_data.kind == KIND_PREPEND ||
        s_data.kind == KIND_APPEND || s_data.kind == KIND_INSERT) |=>
        $countones(cell_valid) == $past($countones(cell_valid)) + 1)
        else $error("insert did not add one entry");
`endif

endmodule
